// ===== rtl/stbs_pkg.sv =====
// Package for the sorted-table binary search core.
// Holds the channel payload structs, opcode and register codes, and the
// sequencer state type. No dependencies.
package stbs_pkg;

   localparam int unsigned INDEX_W = 10;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 11;
   localparam int unsigned COUNT_W = 11;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ORDER_DESC  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 1'b1;

   typedef struct packed {
      logic                      opcode;
      logic [INDEX_W-1:0]        entry_index;
      logic signed [VALUE_W-1:0] data_value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] match_index;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROBE,
      S_CMP,
      S_FIN
   } state_type;

endpackage

// ===== rtl/sorted_table_binary_search_core.sv =====
// Sorted-table binary search core: sequencer, bounds datapath and table RAM.
// Depends on stbs_pkg and stbs_ram.
//
// Usage:
//   req channel (valid/ready) carries write and search items. A write stores
//   data_value into table slot entry_index in the transfer cycle and gives no
//   response. A search bisects slots 0 .. min(entry_count, DEPTH)-1 for data_value.
//   rsp channel (valid/ready) returns found and match_index, one per search.
//   csr channel (valid/ready, always ready) sets order_descending (index 0)
//   and entry_count (index 1); write it only while the core is idle.
// Timing:
//   Each probe drives the address to the RAM read port in the probe state, then
//   compares the registered read data against the key in the compare state.
//   A hit goes from the compare state to the finish state, a miss after a last
//   bounds check in the probe state, with at most P = floor(log2(count)) + 1
//   probes (count capped at DEPTH). The finish step loads the response register.
//   req_ready is high only while the sequencer is idle, which it reaches as
//   the response goes valid, so the core takes no new item while a search runs.
//   The single RAM read port and the shared bounds adder serialise the probes.
// Reset and stalls:
//   Reset clears the sequencer, the response valid and both config
//   registers. The table is not cleared; unwritten slots read undefined.
//   A stalled response sits in the output register; further writes are still
//   taken, and a following search waits in its finish step until it drains.
module sorted_table_binary_search_core #(
   parameter int unsigned DEPTH      = 1024,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  stbs_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output stbs_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [stbs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [stbs_pkg::CSR_DATA_W-1:0]     csr_data
);

   import stbs_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned IW = (AW > INDEX_W) ? AW : INDEX_W;
   localparam int unsigned XW = (CW > COUNT_W) ? CW : COUNT_W;

   state_type state_ff, state_in;

   logic               order_desc_ff;
   logic [COUNT_W-1:0] entry_count_ff;

   logic signed [DATA_WIDTH-1:0] key_ff, key_in;
   logic [CW-1:0]                lo_ff, lo_in;
   logic [CW-1:0]                end_ff, end_in;
   logic [AW-1:0]                mid_ff, mid_in;
   logic                         hit_ff, hit_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   logic                         req_fire;
   logic                         mem_we;
   logic [AW-1:0]                mem_waddr;
   logic                         mem_re;
   logic signed [DATA_WIDTH-1:0] mem_rdata;
   logic signed [DATA_WIDTH-1:0] req_word;
   logic [IW-1:0]                slot_wide;
   logic [XW-1:0]                count_wide;
   logic [CW-1:0]                count_clamp;
   logic [CW:0]                  mid_sum;
   logic                         go_up;
   logic                         rsp_free;
   logic [IW-1:0]                mid_wide;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_desc_ff  <= 1'b0;
         entry_count_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ORDER_DESC:  order_desc_ff  <= csr_data[0];
            CSR_ENTRY_COUNT: entry_count_ff <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- table RAM ----------------
   assign req_fire  = req_valid && req_ready;
   assign req_word  = DATA_WIDTH'(req_data.data_value);
   assign slot_wide = IW'(req_data.entry_index);
   assign mem_waddr = slot_wide[AW-1:0];

   stbs_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (req_word),
      .rd_en   (mem_re),
      .rd_addr (mid_in),
      .rd_data (mem_rdata)
   );

   // ---------------- shared bounds / compare unit ----------------
   assign count_wide  = XW'(entry_count_ff);
   assign count_clamp = (count_wide > XW'(DEPTH)) ? CW'(DEPTH) : count_wide[CW-1:0];
   // floor midpoint of [lo, end-1]; only used while lo < end
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, end_ff} - (CW + 1)'(1);
   assign go_up    = order_desc_ff ? (key_ff < mem_rdata) : (mem_rdata < key_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign mid_wide = IW'(mid_ff);

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_data.opcode == OP_SEARCH) begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            state_in = (lo_ff < end_ff) ? S_CMP : S_FIN;
         end
         S_CMP: begin
            state_in = (mem_rdata == key_ff) ? S_FIN : S_PROBE;
         end
         S_FIN: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            mem_we    = req_fire && req_data.opcode == OP_WRITE &&
                        ({1'b0, slot_wide} < (IW + 1)'(DEPTH));
         end
         S_PROBE: mem_re = lo_ff < end_ff;
         S_CMP:   ;
         S_FIN:   ;
         default: ;
      endcase
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      key_in       = key_ff;
      lo_in        = lo_ff;
      end_in       = end_ff;
      mid_in       = mid_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            key_in = req_word;
            lo_in  = '0;
            end_in = count_clamp;
            hit_in = 1'b0;
         end
         S_PROBE: begin
            mid_in = mid_sum[AW:1];
         end
         S_CMP: begin
            if (mem_rdata == key_ff) begin
               hit_in = 1'b1;
            end else if (go_up) begin
               lo_in = CW'(mid_ff) + CW'(1);
            end else begin
               end_in = CW'(mid_ff);
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.found       = hit_ff;
               rsp_in.match_index = hit_ff ? mid_wide[INDEX_W-1:0] : '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         lo_ff        <= '0;
         end_ff       <= '0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lo_ff        <= lo_in;
         end_ff       <= end_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      mid_ff <= mid_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // a compare step always follows the probe that issued its read
   a_cmp_after_probe: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> $past(state_ff) == S_PROBE)
      else $error("compare step without a preceding probe");

   // the search window never inverts
   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PROBE |-> lo_ff <= end_ff)
      else $error("search bounds inverted");

   // finish is reached only from the search steps
   a_fin_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN |-> ($past(state_ff) == S_PROBE ||
                             $past(state_ff) == S_CMP || $past(state_ff) == S_FIN))
      else $error("finish step entered from idle");
`endif

endmodule

// ===== rtl/stbs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module stbs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== verif/sorted_table_binary_search_core_tb.sv =====
// Self-checking testbench for sorted_table_binary_search_core: directed rows, then
// random table loads and key lookups checked against a bisection predictor.
// Depends on stbs_pkg and the core RTL.
module sorted_table_binary_search_core_tb;
   import stbs_pkg::*;

   localparam int TABLE_DEPTH  = 1024;
   localparam int RAND_ITEMS   = 1800;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int COUNT_MAX    = (1 << COUNT_W) - 1;
   localparam int VAL_MIN      = -2147483647 - 1;
   localparam int VAL_MAX      = 2147483647;

   typedef struct packed {
      logic                  is_csr;
      logic [CSR_IDX_W-1:0]  reg_sel;
      logic [CSR_DATA_W-1:0] reg_val;
      req_type               item;
      logic                  typed;
      rsp_type               want;
   } plan_row_type;

   typedef enum {RX_OPEN, RX_RANDOM, RX_PULSED, RX_STARVED} rx_mode_type;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // mirror of the block's table and registers
   logic signed [VALUE_W-1:0] table_mirror [TABLE_DEPTH];
   logic                      order_desc_m  = 1'b0;
   logic [COUNT_W-1:0]        entry_count_m = '0;

   rsp_type      pending_lookups [$];
   rsp_type      head;
   plan_row_type directed [$];
   int           mismatches   = 0;
   int           results_seen = 0;
   int           items_sent   = 0;
   int           cycle_count  = 0;
   int           burst_left   = 8;
   int           stall_tick   = 0;
   int           first_random;
   bit           valid_up     = 1'b0;
   rx_mode_type  rx_mode      = RX_OPEN;

   sorted_table_binary_search_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // floor-midpoint bisection over slots 0 .. count-1, count capped at the table depth
   function automatic rsp_type bisect_table(logic signed [VALUE_W-1:0] key);
      int lo, hi, mid, n;
      logic signed [VALUE_W-1:0] probe;
      bit go_up;
      rsp_type res;
      res = '0;
      n = int'(entry_count_m);
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         probe = table_mirror[mid];
         if (probe == key) begin
            res.found = 1'b1;
            res.match_index = INDEX_W'(mid);
            break;
         end
         go_up = order_desc_m ? (key < probe) : (probe < key);
         if (go_up) lo = mid + 1;
         else hi = mid - 1;
      end
      return res;
   endfunction

   function automatic plan_row_type wr_row(int slot, int value);
      plan_row_type r;
      r = '0;
      r.item.opcode = OP_WRITE;
      r.item.entry_index = INDEX_W'(slot);
      r.item.data_value = value;
      return r;
   endfunction

   function automatic plan_row_type find_row(int key, bit typed = 1'b0, bit hit = 1'b0,
                                             int slot = 0);
      plan_row_type r;
      r = '0;
      r.item.opcode = OP_SEARCH;
      r.item.entry_index = INDEX_W'($urandom);
      r.item.data_value = key;
      r.typed = typed;
      r.want.found = hit;
      r.want.match_index = INDEX_W'(slot);
      return r;
   endfunction

   function automatic plan_row_type csr_row(logic [CSR_IDX_W-1:0] sel, int value);
      plan_row_type r;
      r = '0;
      r.is_csr = 1'b1;
      r.reg_sel = sel;
      r.reg_val = CSR_DATA_W'(value);
      return r;
   endfunction

   function automatic int pick_key(int n);
      int r;
      r = $urandom_range(0, 99);
      if (n > 0 && r < 60) return table_mirror[$urandom_range(0, n - 1)];
      if (n > 0 && r < 75)
         return table_mirror[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
      if (r < 85) begin
         case ($urandom_range(0, 2))
            0: return VAL_MIN;
            1: return VAL_MAX;
            default: return 0;
         endcase
      end
      return int'($urandom);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("result %0d: %s: got %0d, expected %0d", results_seen, what, got, want);
      mismatches++;
   endtask

   task automatic drop_req_valid();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
   endtask

   // one transfer on the request channel, then the burst/gap pattern
   task automatic send_item(req_type item, bit typed, rsp_type want);
      req_valid <= 1'b1;
      req_data <= item;
      valid_up = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      items_sent++;
      if (item.opcode == OP_WRITE) table_mirror[item.entry_index] = item.data_value;
      else pending_lookups.push_back(typed ? want : bisect_table(item.data_value));
      burst_left--;
      if (burst_left <= 0) begin
         drop_req_valid();
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] sel, logic [CSR_DATA_W-1:0] value,
                            bit last);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      if (sel == CSR_ORDER_DESC) order_desc_m = value[0];
      else entry_count_m = COUNT_W'(value);
      if (last) csr_valid <= 1'b0;
   endtask

   // hold off until every lookup has answered and the core has settled
   task automatic wait_idle();
      drop_req_valid();
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // set order and count, load a sorted prefix, then a mix of lookups and stray writes
   task automatic run_phase(bit fill_all);
      int pick, cnt, n_load, n_eff, n_ops, base, i;
      bit desc, flip, narrow;
      int vals [$];
      req_type item;
      wait_idle();
      desc = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (fill_all) begin
         cnt = (pick < 50) ? TABLE_DEPTH : $urandom_range(TABLE_DEPTH + 1, COUNT_MAX);
         n_load = TABLE_DEPTH;
      end else if (pick < 8) begin
         cnt = 0;
         n_load = 0;
      end else if (pick < 12) begin
         // stale table past the loaded prefixes: unsorted lookups
         cnt = $urandom_range(TABLE_DEPTH, COUNT_MAX);
         n_load = 0;
      end else if (pick < 20) begin
         cnt = $urandom_range(65, 300);
         n_load = cnt;
      end else begin
         cnt = $urandom_range(1, 64);
         n_load = cnt;
      end
      write_csr(CSR_ORDER_DESC, CSR_DATA_W'(desc), 1'b0);
      write_csr(CSR_ENTRY_COUNT, CSR_DATA_W'(cnt), 1'b1);

      flip = ($urandom_range(0, 9) == 0);
      narrow = $urandom_range(0, 1);
      base = int'($urandom);
      for (i = 0; i < n_load; i++)
         vals.push_back(narrow ? base + int'($urandom_range(0, 2 * n_load)) : int'($urandom));
      if (n_load >= 2 && $urandom_range(0, 3) == 0) begin
         vals[0] = VAL_MIN;
         vals[n_load - 1] = VAL_MAX;
      end
      if (desc ^ flip) vals.rsort();
      else vals.sort();
      for (i = 0; i < n_load; i++) begin
         item.opcode = OP_WRITE;
         item.entry_index = INDEX_W'(i);
         item.data_value = vals[i];
         send_item(item, 1'b0, '0);
      end

      n_eff = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
      n_ops = (cnt == 0) ? $urandom_range(4, 10) : $urandom_range(10, 60);
      for (i = 0; i < n_ops; i++) begin
         if ($urandom_range(0, 99) < 12) begin
            item.opcode = OP_WRITE;
            item.entry_index = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
            item.data_value = int'($urandom);
         end else begin
            item.opcode = OP_SEARCH;
            item.entry_index = INDEX_W'($urandom);
            item.data_value = pick_key(n_eff);
         end
         send_item(item, 1'b0, '0);
      end
   endtask

   // response checker and receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_lookups.size() == 0) begin
            report_mismatch("result with no lookup pending", rsp_data.match_index, 0);
         end else begin
            head = pending_lookups.pop_front();
            if (rsp_data.found !== head.found)
               report_mismatch("found", rsp_data.found, head.found);
            if (rsp_data.match_index !== head.match_index)
               report_mismatch("match_index", rsp_data.match_index, head.match_index);
         end
      end
      stall_tick++;
      if (stall_tick % 400 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
         RX_PULSED: rsp_ready <= ((stall_tick % 7) < 3);
         default:   rsp_ready <= ((stall_tick % 24) == 0);
      endcase
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      directed = '{
         find_row(0, 1'b1, 1'b0, 0),              // empty table after reset
         wr_row(0, VAL_MIN),
         wr_row(1, -5),
         wr_row(2, 0),
         wr_row(3, 7),
         wr_row(4, VAL_MAX),
         wr_row(TABLE_DEPTH - 1, 32'sh5A5A_A5A5),
         csr_row(CSR_ENTRY_COUNT, 5),
         find_row(VAL_MIN, 1'b1, 1'b1, 0),
         find_row(VAL_MAX, 1'b1, 1'b1, 4),
         find_row(0, 1'b1, 1'b1, 2),
         find_row(3, 1'b1, 1'b0, 0),
         find_row(-5),
         csr_row(CSR_ORDER_DESC, 1),               // ascending data, descending walk
         find_row(7),
         wr_row(0, VAL_MAX),
         wr_row(1, 7),
         wr_row(2, 0),
         wr_row(3, -5),
         wr_row(4, VAL_MIN),
         find_row(VAL_MIN),
         find_row(7),
         find_row(-1, 1'b1, 1'b0, 0),
         csr_row(CSR_ENTRY_COUNT, 1),
         find_row(VAL_MAX, 1'b1, 1'b1, 0)
      };
      foreach (directed[k]) begin
         if (directed[k].is_csr) begin
            wait_idle();
            write_csr(directed[k].reg_sel, directed[k].reg_val, 1'b1);
         end else begin
            send_item(directed[k].item, directed[k].typed, directed[k].want);
         end
      end

      // first phase loads the whole table so any count is safe afterwards
      first_random = items_sent;
      run_phase(1'b1);
      while (items_sent < first_random + RAND_ITEMS) run_phase(1'b0);

      wait_idle();
      if (mismatches == 0 && pending_lookups.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
